// ===== rtl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants of the label setting command decoder: the
// settings record, command letters, event and status codes, register map.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  // The eight label settings, also used for the default register bank.
  typedef struct packed {
    logic [11:0] width;
    logic [11:0] height;
    logic [7:0]  gap;
    logic [3:0]  font;
    logic [3:0]  x_scale;
    logic [3:0]  y_scale;
    logic [11:0] left;
    logic [11:0] top;
  } settings_t;

  localparam settings_t SETTINGS_RESET = '{
    width:   12'd400,
    height:  12'd240,
    gap:     8'd16,
    font:    4'd1,
    x_scale: 4'd1,
    y_scale: 4'd1,
    left:    12'd0,
    top:     12'd0
  };

  // Register indexes of the default bank.
  localparam logic [2:0] REG_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_GAP     = 3'd2;
  localparam logic [2:0] REG_FONT    = 3'd3;
  localparam logic [2:0] REG_X_SCALE = 3'd4;
  localparam logic [2:0] REG_Y_SCALE = 3'd5;
  localparam logic [2:0] REG_LEFT    = 3'd6;
  localparam logic [2:0] REG_TOP     = 3'd7;

  // Command letters in ASCII.
  localparam logic [7:0] CMD_WIDTH   = 8'h57; // W
  localparam logic [7:0] CMD_HEIGHT  = 8'h48; // H
  localparam logic [7:0] CMD_GAP     = 8'h47; // G
  localparam logic [7:0] CMD_FONT    = 8'h46; // F
  localparam logic [7:0] CMD_X_SCALE = 8'h58; // X
  localparam logic [7:0] CMD_Y_SCALE = 8'h59; // Y
  localparam logic [7:0] CMD_LEFT    = 8'h4C; // L
  localparam logic [7:0] CMD_TOP     = 8'h54; // T
  localparam logic [7:0] CMD_DEFAULT = 8'h44; // D
  localparam logic [7:0] CMD_LOAD    = 8'h52; // R
  localparam logic [7:0] CMD_SAVE    = 8'h53; // S
  localparam logic [7:0] CMD_PRINT   = 8'h50; // P

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PRINT = 2'd1,
    KIND_SAVE  = 2'd2,
    KIND_LOAD  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_CHANGED  = 2'd0,
    ST_REQUEST  = 2'd1,
    ST_REJECTED = 2'd2,
    ST_UNKNOWN  = 2'd3
  } status_e;

  // Millimetres to dots at eight dots per millimetre.
  function automatic logic [11:0] mm_to_dots(input logic [7:0] mm);
    mm_to_dots = {1'b0, mm, 3'b000};
  endfunction

  // Tenths of a millimetre to dots, rounded: (v*8+5)/10. The divide by ten
  // is a multiply by 3277/32768, exact for every dividend below 2048.
  function automatic logic [7:0] tenths_to_dots(input logic [7:0] tenths);
    logic [10:0] num;
    logic [22:0] prod;
    num  = {tenths, 3'b000} + 11'd5;
    prod = 23'(num) * 23'd3277;
    tenths_to_dots = prod[22:15];
  endfunction

endpackage

// ===== rtl/lsc_intf.sv =====
// ----------------------------------------------------------------------------
// lsc_intf
// Valid/ready channels of the label setting command decoder: the command
// request channel and the result channel.
// ----------------------------------------------------------------------------
interface lsc_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] command;
  logic [7:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface lsc_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] label_width_dots;
  logic [11:0] label_height_dots;
  logic [7:0]  gap_dots;
  logic [3:0]  font_number;
  logic [3:0]  font_x_scale;
  logic [3:0]  font_y_scale;
  logic [11:0] left_margin_dots;
  logic [11:0] top_margin_dots;
  logic [1:0]  request_kind;
  logic [3:0]  request_slot;
  logic [1:0]  status;

  modport source (
    output valid, output label_width_dots, output label_height_dots,
    output gap_dots, output font_number, output font_x_scale,
    output font_y_scale, output left_margin_dots, output top_margin_dots,
    output request_kind, output request_slot, output status,
    input ready
  );
  modport sink (
    input valid, input label_width_dots, input label_height_dots,
    input gap_dots, input font_number, input font_x_scale,
    input font_y_scale, input left_margin_dots, input top_margin_dots,
    input request_kind, input request_slot, input status,
    output ready
  );
endinterface

// ===== rtl/lsc_cfg.sv =====
// ----------------------------------------------------------------------------
// lsc_cfg
// APB register bank holding the eight default settings that the reset-to-
// defaults command loads.
// ----------------------------------------------------------------------------
module lsc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lsc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lsc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lsc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output lsc_pkg::settings_t              defaults_o
);

  lsc_pkg::settings_t defaults_q;
  logic               wr_en;
  logic [2:0]         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      defaults_q <= lsc_pkg::SETTINGS_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        lsc_pkg::REG_WIDTH:   defaults_q.width   <= pwdata[11:0];
        lsc_pkg::REG_HEIGHT:  defaults_q.height  <= pwdata[11:0];
        lsc_pkg::REG_GAP:     defaults_q.gap     <= pwdata[7:0];
        lsc_pkg::REG_FONT:    defaults_q.font    <= pwdata[3:0];
        lsc_pkg::REG_X_SCALE: defaults_q.x_scale <= pwdata[3:0];
        lsc_pkg::REG_Y_SCALE: defaults_q.y_scale <= pwdata[3:0];
        lsc_pkg::REG_LEFT:    defaults_q.left    <= pwdata[11:0];
        lsc_pkg::REG_TOP:     defaults_q.top     <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lsc_pkg::REG_WIDTH:   prdata = 32'(defaults_q.width);
      lsc_pkg::REG_HEIGHT:  prdata = 32'(defaults_q.height);
      lsc_pkg::REG_GAP:     prdata = 32'(defaults_q.gap);
      lsc_pkg::REG_FONT:    prdata = 32'(defaults_q.font);
      lsc_pkg::REG_X_SCALE: prdata = 32'(defaults_q.x_scale);
      lsc_pkg::REG_Y_SCALE: prdata = 32'(defaults_q.y_scale);
      lsc_pkg::REG_LEFT:    prdata = 32'(defaults_q.left);
      lsc_pkg::REG_TOP:     prdata = 32'(defaults_q.top);
      default:              prdata = '0;
    endcase
  end

  assign defaults_o = defaults_q;

endmodule

// ===== rtl/label_setting_command_decoder.sv =====
// ----------------------------------------------------------------------------
// label_setting_command_decoder
// Decodes label printer setting commands, keeps the eight label settings and
// reports them with any print, save or load event for every request.
// ----------------------------------------------------------------------------
// One command request is taken per clock cycle while the command register is
// empty or its command moves on into the result register. The rate is set by
// the single decode stage that sits between the command register and the
// result register; a stalled result only holds the command register behind
// it, so a command can wait there before its result is registered.
// The result always shows the eight settings as they stand after the command.
// The default settings live in APB registers at byte address 4*index and are
// copied into the live settings by a D command with value zero.
module label_setting_command_decoder #(
  parameter int unsigned SLOT_COUNT = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lsc_cmd_if.sink                         cmd_i,
  lsc_res_if.source                       res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lsc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lsc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lsc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  lsc_pkg::settings_t defaults;

  logic               in_valid_q;
  logic [7:0]         cmd_q;
  logic [7:0]         val_q;
  logic               out_valid_q;
  lsc_pkg::settings_t settings_q, settings_d;
  lsc_pkg::kind_e     kind_q, kind_d;
  logic [3:0]         slot_q, slot_d;
  lsc_pkg::status_e   status_q, status_d;

  logic accept;
  logic advance;
  logic small_ok;
  logic slot_ok;

  lsc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .defaults_o (defaults)
  );

  // The decode stage moves on when the result register is empty or drained.
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !in_valid_q || advance;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i.command;
      val_q <= cmd_i.value;
    end
  end

  assign small_ok = (val_q >= 8'd1) && (val_q <= 8'd8);
  assign slot_ok  = {1'b0, val_q} < 9'(SLOT_COUNT);

  always_comb begin
    settings_d = settings_q;
    kind_d     = lsc_pkg::KIND_NONE;
    slot_d     = 4'd0;
    status_d   = lsc_pkg::ST_CHANGED;
    case (cmd_q)
      lsc_pkg::CMD_WIDTH: begin
        if (val_q != 8'd0) settings_d.width = lsc_pkg::mm_to_dots(val_q);
        else status_d = lsc_pkg::ST_REJECTED;
      end
      lsc_pkg::CMD_HEIGHT: begin
        if (val_q != 8'd0) settings_d.height = lsc_pkg::mm_to_dots(val_q);
        else status_d = lsc_pkg::ST_REJECTED;
      end
      lsc_pkg::CMD_GAP: settings_d.gap = lsc_pkg::tenths_to_dots(val_q);
      lsc_pkg::CMD_FONT: begin
        if (small_ok) settings_d.font = val_q[3:0];
        else status_d = lsc_pkg::ST_REJECTED;
      end
      lsc_pkg::CMD_X_SCALE: begin
        if (small_ok) settings_d.x_scale = val_q[3:0];
        else status_d = lsc_pkg::ST_REJECTED;
      end
      lsc_pkg::CMD_Y_SCALE: begin
        if (small_ok) settings_d.y_scale = val_q[3:0];
        else status_d = lsc_pkg::ST_REJECTED;
      end
      lsc_pkg::CMD_LEFT: settings_d.left = lsc_pkg::mm_to_dots(val_q);
      lsc_pkg::CMD_TOP:  settings_d.top  = lsc_pkg::mm_to_dots(val_q);
      lsc_pkg::CMD_DEFAULT: begin
        if (val_q == 8'd0) settings_d = defaults;
        else status_d = lsc_pkg::ST_REJECTED;
      end
      lsc_pkg::CMD_SAVE, lsc_pkg::CMD_LOAD: begin
        if (slot_ok) begin
          kind_d   = (cmd_q == lsc_pkg::CMD_SAVE) ? lsc_pkg::KIND_SAVE
                                                  : lsc_pkg::KIND_LOAD;
          slot_d   = val_q[3:0];
          status_d = lsc_pkg::ST_REQUEST;
        end else begin
          status_d = lsc_pkg::ST_REJECTED;
        end
      end
      lsc_pkg::CMD_PRINT: begin
        kind_d   = lsc_pkg::KIND_PRINT;
        status_d = lsc_pkg::ST_REQUEST;
      end
      default: status_d = lsc_pkg::ST_UNKNOWN;
    endcase
  end

  // The live settings double as the settings part of the result register:
  // they only change when a new result is loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      settings_q  <= lsc_pkg::SETTINGS_RESET;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      settings_q  <= settings_d;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q   <= kind_d;
      slot_q   <= slot_d;
      status_q <= status_d;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.label_width_dots  = settings_q.width;
  assign res_o.label_height_dots = settings_q.height;
  assign res_o.gap_dots          = settings_q.gap;
  assign res_o.font_number       = settings_q.font;
  assign res_o.font_x_scale      = settings_q.x_scale;
  assign res_o.font_y_scale      = settings_q.y_scale;
  assign res_o.left_margin_dots  = settings_q.left;
  assign res_o.top_margin_dots   = settings_q.top;
  assign res_o.request_kind      = kind_q;
  assign res_o.request_slot      = slot_q;
  assign res_o.status            = status_q;

endmodule
